// File: rtl/core/bmfb_pkg.sv
`timescale 1ns / 1ps

package bmfb_pkg;

    // Command codes carried in the request's tuser.
    typedef enum logic [2:0] {
        KIND_SET     = 3'd0,
        KIND_CLR     = 3'd1,
        KIND_OUTLINE = 3'd2,
        KIND_FILL    = 3'd3,
        KIND_CLEAR   = 3'd4,
        KIND_READ    = 3'd5
    } kind_t;

    // Width of the internal coordinate arithmetic (rows and columns up to 511).
    localparam int CRD_W = 9;

    // One drawing request as taken from the input channel.
    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] pixel_row;
        logic [6:0] pixel_col;
        logic [5:0] span_rows;
        logic [6:0] span_cols;
        logic [2:0] read_bank;
    } cmd_t;

    // One result handed to the output register.
    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } res_t;

endpackage

// File: rtl/core/bmfb_store.sv
`timescale 1ns / 1ps

module bmfb_store #(
    parameter int DEPTH  = 504,
    parameter int ADDR_W = 9
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/bmfb_engine.sv
`timescale 1ns / 1ps

module bmfb_engine #(
    parameter int NUM_BANKS   = 6,
    parameter int NUM_COLUMNS = 84
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  bmfb_pkg::cmd_t  cmd,
    output logic            ready,
    input  logic            out_free,
    output logic            res_valid,
    output bmfb_pkg::res_t  res
);

    import bmfb_pkg::*;

    localparam int DEPTH  = NUM_BANKS * NUM_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int COL_W  = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    localparam logic [CRD_W-1:0]  TOT_ROWS  = CRD_W'(NUM_BANKS * 8);
    localparam logic [CRD_W-1:0]  NCOLS_C   = CRD_W'(NUM_COLUMNS);
    localparam logic [CRD_W-1:0]  NBANKS_C  = CRD_W'(NUM_BANKS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(NUM_COLUMNS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_WALK  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_RESP  = 6'b010000,
        ST_CLEAR = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_CLR  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    op_t                 op_reg;
    logic                outline_reg;
    logic [CRD_W-1:0]    r_lo_reg, r_hi_reg, c_end_reg;
    logic [BANK_W-1:0]   bank_reg, bank_hi_reg;
    logic [COL_W-1:0]    col_reg, col_lo_reg, col_hi_reg;
    logic [ADDR_W-1:0]   row_base_reg;
    logic                clip_reg;
    logic [7:0]          data_reg;
    logic                sweep_reply_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic                pend_valid_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic [7:0]          pend_mask_reg;
    op_t                 pend_op_reg;

    // Setup decode results.
    logic [CRD_W-1:0]    row9, col9, r_end, c_end, r_end_cl, c_end_cl;
    logic                row_off, col_off, zero_span;
    logic                s_skip, s_clip, s_outline;
    op_t                 s_op;
    logic [CRD_W-1:0]    s_r_lo, s_r_hi, s_bank_lo, s_bank_hi, s_col_lo, s_col_hi;

    // Walk signals.
    logic [CRD_W-1:0]    row_i;
    logic                at_edge;
    logic [7:0]          mask;
    logic                walk_last;

    // Memory port.
    logic                rd_en, wr_en;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic [7:0]          rd_data, wr_data;

    bmfb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Decode the request into a bank and column range, a row range and a clip flag.
    always_comb begin
        row9      = CRD_W'(cmd_reg.pixel_row);
        col9      = CRD_W'(cmd_reg.pixel_col);
        r_end     = row9 + CRD_W'(cmd_reg.span_rows) - CRD_W'(1);
        c_end     = col9 + CRD_W'(cmd_reg.span_cols) - CRD_W'(1);
        r_end_cl  = (r_end >= TOT_ROWS) ? TOT_ROWS - CRD_W'(1) : r_end;
        c_end_cl  = (c_end >= NCOLS_C) ? NCOLS_C - CRD_W'(1) : c_end;
        row_off   = (row9 >= TOT_ROWS);
        col_off   = (col9 >= NCOLS_C);
        zero_span = (cmd_reg.span_rows == '0) || (cmd_reg.span_cols == '0);

        s_skip    = 1'b1;
        s_clip    = 1'b0;
        s_outline = 1'b0;
        s_op      = OP_SET;
        s_r_lo    = row9;
        s_r_hi    = row9;
        s_bank_lo = row9 >> 3;
        s_bank_hi = row9 >> 3;
        s_col_lo  = col9;
        s_col_hi  = col9;

        case (cmd_reg.kind)
            KIND_SET, KIND_CLR: begin
                s_skip = row_off || col_off;
                s_clip = row_off || col_off;
                s_op   = (cmd_reg.kind == KIND_SET) ? OP_SET : OP_CLR;
            end
            KIND_OUTLINE, KIND_FILL: begin
                s_skip    = zero_span || row_off || col_off;
                s_clip    = !zero_span && ((r_end >= TOT_ROWS) || (c_end >= NCOLS_C));
                s_outline = (cmd_reg.kind == KIND_OUTLINE);
                s_r_hi    = r_end;
                s_bank_hi = r_end_cl >> 3;
                s_col_hi  = c_end_cl;
            end
            KIND_READ: begin
                s_skip    = (CRD_W'(cmd_reg.read_bank) >= NBANKS_C) || col_off;
                s_clip    = s_skip;
                s_op      = OP_READ;
                s_bank_lo = CRD_W'(cmd_reg.read_bank);
                s_bank_hi = CRD_W'(cmd_reg.read_bank);
            end
            default: begin
                s_skip = 1'b1;
                s_clip = 1'b0;
            end
        endcase
    end

    // Bit mask of the current byte; outlines keep only edge columns and edge rows.
    always_comb begin
        row_i   = '0;
        at_edge = (CRD_W'(col_reg) == CRD_W'(col_lo_reg)) || (CRD_W'(col_reg) == c_end_reg);
        for (int i = 0; i < 8; i++) begin
            row_i   = {(CRD_W-3)'(bank_reg), 3'(i)};
            mask[i] = (row_i >= r_lo_reg) && (row_i <= r_hi_reg) &&
                      (!outline_reg || at_edge || (row_i == r_lo_reg) || (row_i == r_hi_reg));
        end
        walk_last = (col_reg == col_hi_reg) && (bank_reg == bank_hi_reg);
    end

    // Memory port: reads come from the walk, writes from the modify stage or the sweep.
    always_comb begin
        rd_en   = (state_reg == ST_WALK);
        rd_addr = row_base_reg + ADDR_W'(col_reg);
        wr_en   = (state_reg == ST_CLEAR) || (pend_valid_reg && (pend_op_reg != OP_READ));
        wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : pend_addr_reg;
        case (pend_op_reg)
            OP_SET:  wr_data = rd_data | pend_mask_reg;
            OP_CLR:  wr_data = rd_data & ~pend_mask_reg;
            default: wr_data = rd_data;
        endcase
        if (state_reg == ST_CLEAR) begin
            wr_data = '0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (cmd_reg.kind == KIND_CLEAR) begin
                    state_next = ST_CLEAR;
                end else if (s_skip) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = sweep_reply_reg ? ST_RESP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers; after reset the store is swept to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            sweep_reply_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= (state_reg == ST_WALK);
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (state_reg == ST_SETUP) begin
                clr_cnt_reg     <= '0;
                sweep_reply_reg <= 1'b1;
            end
        end
    end

    // Request capture, walk counters and the modify stage.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_SETUP) begin
            op_reg       <= s_op;
            outline_reg  <= s_outline;
            r_lo_reg     <= s_r_lo;
            r_hi_reg     <= s_r_hi;
            c_end_reg    <= c_end;
            bank_reg     <= BANK_W'(s_bank_lo);
            bank_hi_reg  <= BANK_W'(s_bank_hi);
            col_reg      <= COL_W'(s_col_lo);
            col_lo_reg   <= COL_W'(s_col_lo);
            col_hi_reg   <= COL_W'(s_col_hi);
            row_base_reg <= ADDR_W'(s_bank_lo) * ROW_STEP;
            clip_reg     <= s_clip;
            data_reg     <= '0;
        end
        if (state_reg == ST_WALK) begin
            pend_addr_reg <= rd_addr;
            pend_mask_reg <= mask;
            pend_op_reg   <= op_reg;
            if (col_reg == col_hi_reg) begin
                col_reg      <= col_lo_reg;
                bank_reg     <= bank_reg + BANK_W'(1);
                row_base_reg <= row_base_reg + ROW_STEP;
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
        if (pend_valid_reg && pend_op_reg == OP_READ) begin
            data_reg <= rd_data;
        end
        if (state_reg == ST_CLEAR) begin
            clip_reg <= 1'b0;
            data_reg <= '0;
        end
    end

    assign ready         = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_RESP) && out_free;
    assign res.read_data = data_reg;
    assign res.clipped   = clip_reg;

    // The modify stage only ever follows a walk read.
    a_pend_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> $past(state_reg == ST_WALK))
        else $error("modify stage active without a preceding read");

    // Walk reads stay inside the store.
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (rd_addr <= LAST_ADDR))
        else $error("walk address beyond the store");

    // A new request is taken only once the previous write has landed.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP) |-> !pend_valid_reg)
        else $error("request started while a write is pending");

    // A delivered result returns the engine to idle.
    a_resp_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (state_reg == ST_IDLE))
        else $error("engine did not return to idle after a result");

endmodule

// File: rtl/core/banked_mono_framebuffer_draw.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   tuser: kind; tdata: row, col, spans, bank
// m_        out        m_tvalid/m_tready   tdata: read_data; tuser: clipped
//
// One request at a time: a pixel set/clear does one read-modify-write and a byte read one
// read, a rectangle one read-modify-write per byte of the clipped bank/column range, and
// a request that touches no byte (off the display, zero-sized or an unused kind) none.
// Clear all writes zero to all NUM_BANKS * NUM_COLUMNS bytes (504 at the defaults).
// After reset a clearing pass over the whole store runs before s_tready rises.
// The next request is taken while a result still waits in the output register.

module banked_mono_framebuffer_draw #(
    parameter int NUM_BANKS   = 6,
    parameter int NUM_COLUMNS = 84
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_row[5:0], pixel_col[12:6], span_rows[18:13],
                                   // span_cols[25:19], read_bank[28:26], zero fill
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_data[7:0]
    output logic        m_tuser    // clipped
);

    import bmfb_pkg::*;

    cmd_t       cmd;
    res_t       res;
    logic       eng_ready;
    logic       res_valid;
    logic       out_free;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;

    // Unpack the request.
    assign cmd.kind      = s_tuser;
    assign cmd.pixel_row = s_tdata[5:0];
    assign cmd.pixel_col = s_tdata[12:6];
    assign cmd.span_rows = s_tdata[18:13];
    assign cmd.span_cols = s_tdata[25:19];
    assign cmd.read_bank = s_tdata[28:26];

    assign s_tready = eng_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    bmfb_engine #(
        .NUM_BANKS   (NUM_BANKS),
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && eng_ready),
        .cmd       (cmd),
        .ready     (eng_ready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register decouples the engine from the result consumer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= res.read_data;
            m_tuser_reg <= res.clipped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: tb/banked_mono_framebuffer_draw_test.sv
`timescale 1ns / 1ps

module banked_mono_framebuffer_draw_test;

    import bmfb_pkg::*;

    localparam int BANKS = 6;
    localparam int COLS = 84;
    localparam int ROWS = BANKS * 8;

    // Kinds outside the package enum; the block must ignore them.
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // Longest quiet spell: a full-store pass plus both sides' idle bursts, taken many times over.
    localparam int QUIET_LIMIT = 4000;
    // Settling time after the last result, a little over the longest command.
    localparam int DRAIN_CYCLES = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // pixel_row, pixel_col, span_rows, span_cols, read_bank, zero fill
    logic [2:0]  s_tuser = '0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // read_data
    logic        m_tuser;        // clipped

    // Shadow copy of the display store and the results still owed by the block.
    logic [7:0] shadow_store [BANKS][COLS];
    res_t       pending_results[$];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  source_idle = 1'b1;
    bit  sink_idle = 1'b1;
    int  last_row = 0;
    int  last_col = 0;

    banked_mono_framebuffer_draw #(
        .NUM_BANKS  (BANKS),
        .NUM_COLUMNS(COLS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Sets or clears one pixel of the shadow store. Returns 1 when it lies off the display.
    function automatic bit plot_pixel(int row, int col, bit on);
        if (row >= ROWS || col >= COLS) begin
            return 1'b1;
        end
        shadow_store[row / 8][col][row % 8] = on;
        return 1'b0;
    endfunction

    // Applies one drawing request to the shadow store and returns the result it owes.
    function automatic res_t apply_draw_command(cmd_t c);
        res_t r;
        int top, left, bottom, right;
        int i, j;
        r = '0;
        top = c.pixel_row;
        left = c.pixel_col;
        bottom = top + int'(c.span_rows) - 1;
        right = left + int'(c.span_cols) - 1;
        case (c.kind)
            KIND_SET: begin
                r.clipped = plot_pixel(top, left, 1'b1);
            end
            KIND_CLR: begin
                r.clipped = plot_pixel(top, left, 1'b0);
            end
            KIND_OUTLINE: begin
                // A zero span in either direction draws nothing.
                if (c.span_rows != 0 && c.span_cols != 0) begin
                    for (i = top; i <= bottom; i++) begin
                        r.clipped |= plot_pixel(i, left, 1'b1);
                        r.clipped |= plot_pixel(i, right, 1'b1);
                    end
                    for (i = left; i <= right; i++) begin
                        r.clipped |= plot_pixel(top, i, 1'b1);
                        r.clipped |= plot_pixel(bottom, i, 1'b1);
                    end
                end
            end
            KIND_FILL: begin
                if (c.span_rows != 0 && c.span_cols != 0) begin
                    for (i = top; i <= bottom; i++) begin
                        for (j = left; j <= right; j++) begin
                            r.clipped |= plot_pixel(i, j, 1'b1);
                        end
                    end
                end
            end
            KIND_CLEAR: begin
                for (i = 0; i < BANKS; i++) begin
                    for (j = 0; j < COLS; j++) begin
                        shadow_store[i][j] = '0;
                    end
                end
            end
            KIND_READ: begin
                if (c.read_bank < BANKS && c.pixel_col < COLS) begin
                    r.read_data = shadow_store[c.read_bank][c.pixel_col];
                end else begin
                    r.clipped = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Sends one request, optionally after an idle burst, and books its result once accepted.
    task automatic issue_command(input logic [2:0] kind, input int row, input int col,
                                 input int rows, input int cols, input int bank);
        cmd_t c;
        int gap;
        c.kind = kind;
        c.pixel_row = 6'(row);
        c.pixel_col = 7'(col);
        c.span_rows = 6'(rows);
        c.span_cols = 7'(cols);
        c.read_bank = 3'(bank);
        if (source_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.kind;
        s_tdata <= {3'b000, c.read_bank, c.span_cols, c.span_rows, c.pixel_col, c.pixel_row};
        // Values read just after the edge are the ones the block saw at that edge.
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_draw_command(c));
        if (kind != KIND_READ) begin
            last_row = row;
            last_col = col;
        end
    endtask

    // Pixel set and clear with reads, including points just past each edge of the display.
    task automatic test_pixel_commands();
        issue_command(KIND_SET, 0, 0, 0, 0, 0);
        issue_command(KIND_SET, 47, 83, 0, 0, 0);
        issue_command(KIND_READ, 0, 0, 0, 0, 0);
        issue_command(KIND_READ, 0, 83, 0, 0, 5);
        issue_command(KIND_CLR, 0, 0, 0, 0, 0);
        issue_command(KIND_READ, 0, 0, 0, 0, 0);
        issue_command(KIND_SET, 63, 127, 0, 0, 0);
        issue_command(KIND_CLR, 48, 0, 0, 0, 0);
        issue_command(KIND_SET, 0, 84, 0, 0, 0);
    endtask

    // Outlines and fills: in range, clipped, zero-sized, single pixel and the whole screen.
    task automatic test_rectangle_commands();
        issue_command(KIND_OUTLINE, 2, 3, 10, 20, 0);
        issue_command(KIND_READ, 0, 3, 0, 0, 1);
        issue_command(KIND_FILL, 40, 80, 16, 10, 0);
        issue_command(KIND_READ, 0, 83, 0, 0, 5);
        issue_command(KIND_FILL, 5, 5, 0, 10, 0);
        issue_command(KIND_OUTLINE, 5, 5, 10, 0, 0);
        issue_command(KIND_OUTLINE, 20, 10, 1, 1, 0);
        issue_command(KIND_OUTLINE, 63, 127, 63, 127, 0);
        issue_command(KIND_FILL, 0, 0, 48, 84, 0);
        issue_command(KIND_READ, 0, 40, 0, 0, 3);
    endtask

    // Clear all, then reads inside and outside the store.
    task automatic test_clear_and_read();
        issue_command(KIND_CLEAR, 63, 127, 63, 127, 7);
        issue_command(KIND_READ, 0, 0, 0, 0, 7);
        issue_command(KIND_READ, 0, 127, 0, 0, 0);
        issue_command(KIND_READ, 0, 50, 0, 0, 2);
    endtask

    // The two kinds without a command must change nothing and return zero data, clipped clear.
    task automatic test_unused_kinds();
        issue_command(KIND_SPARE_LO, 63, 127, 63, 127, 7);
        issue_command(KIND_SPARE_HI, 0, 0, 0, 0, 0);
    endtask

    // One random request: mostly on-screen coordinates and small rectangles, some strays.
    task automatic send_random_command();
        logic [2:0] kind;
        int sel, row, col, rows, cols, bank;
        sel = $urandom_range(0, 99);
        row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 47);
        col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 83);
        rows = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
        cols = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
        bank = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 5);
        if (sel < 25) begin
            kind = KIND_SET;
        end else if (sel < 35) begin
            kind = KIND_CLR;
        end else if (sel < 50) begin
            kind = KIND_OUTLINE;
        end else if (sel < 65) begin
            kind = KIND_FILL;
        end else if (sel < 68) begin
            kind = KIND_CLEAR;
        end else if (sel < 70) begin
            kind = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
        end else begin
            kind = KIND_READ;
            // Half the reads look at the byte touched last, so they see fresh drawing.
            if ($urandom_range(0, 1) == 0) begin
                bank = last_row / 8;
                col = last_col;
            end
        end
        issue_command(kind, row, col, rows, cols, bank);
    endtask

    // Random drawing in chunks, with idling switched on or off per chunk and side.
    task automatic test_random_drawing(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                source_idle = $urandom_range(0, 2) != 0;
                sink_idle = $urandom_range(0, 2) != 0;
            end
            send_random_command();
        end
    endtask

    // The last stretch runs at full rate on both sides.
    task automatic test_quiet_tail(input int count);
        int n;
        source_idle = 1'b0;
        sink_idle = 1'b0;
        for (n = 0; n < count; n++) begin
            send_random_command();
        end
    endtask

    // Result channel ready, with random stall bursts while enabled.
    initial begin : sink_pacing
        int n;
        forever begin
            @(posedge aclk);
            if (sink_idle && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare every returned result with the oldest one owed.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %0h, clipped %0b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h", want.read_data, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved a request for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int b, k;
        for (b = 0; b < BANKS; b++) begin
            for (k = 0; k < COLS; k++) begin
                shadow_store[b][k] = '0;
            end
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pixel_commands();
        test_rectangle_commands();
        test_clear_and_read();
        test_unused_kinds();
        test_random_drawing(700);
        test_quiet_tail(40);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/bmfb_pkg.sv
rtl/core/bmfb_store.sv
rtl/core/bmfb_engine.sv
rtl/core/banked_mono_framebuffer_draw.sv
tb/banked_mono_framebuffer_draw_test.sv
